@@ sv/sclw_pkg.sv @@
// ----------------------------------------------------------------------------
// sclw_pkg
// Shared types and widths for the sector cache tag and replacement controller.
// ----------------------------------------------------------------------------
package sclw_pkg;

    localparam int SECTOR_W     = 10;
    localparam int STAMP_W      = 32;
    localparam int SLOT_FIELD_W = 3;

    typedef logic [SECTOR_W-1:0]     t_sector;
    typedef logic [STAMP_W-1:0]      t_stamp;
    typedef logic [SLOT_FIELD_W-1:0] t_slot_field;

    typedef struct packed {
        logic    en;
        logic    set_tag;
        logic    dirty;
        t_sector tag;
        t_stamp  stamp;
    } t_store_wr;

endpackage

@@ sv/sector_cache_lru_writeback.sv @@
// ----------------------------------------------------------------------------
// sector_cache_lru_writeback
// Tag and replacement controller for a fully associative, write-back,
// write-allocate disk sector cache with least-recent-stamp replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: i_in_valid / o_in_stall carries one word of mode,
//   sector number and time stamp. Result channel: o_out_valid / i_out_stall
//   carries hit, slot, write-back flag and victim sector.
//   Each request walks the slot store one slot per cycle through its single
//   read port; the same scan finds a hit, the first free slot and the oldest
//   stamp. o_in_stall is high while a request is in flight.
//   The result sits in an output register; a new request may be accepted
//   while it waits. If the receiver still stalls the previous result when
//   the next one is ready, the controller holds in its update step.
//   Reset (synchronous, active low) empties the cache: all slots invalid and
//   clean, no result pending. No clearing pass is needed.
// ----------------------------------------------------------------------------
module sector_cache_lru_writeback #(
    parameter int CACHE_SLOTS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_mode,
    input  sclw_pkg::t_sector      i_sector_number,
    input  sclw_pkg::t_stamp       i_time_now,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_hit,
    output sclw_pkg::t_slot_field  o_slot,
    output logic                   o_writeback_needed,
    output sclw_pkg::t_sector      o_victim_sector
);
    import sclw_pkg::*;

    localparam int IW = $clog2(CACHE_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_SLOTS - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;

    logic [2:0]    r_state, n_state;
    logic [IW-1:0] r_rd_idx;
    logic [IW-1:0] r_cmp_idx;
    logic          r_cmp_en;

    logic          r_mode;
    t_sector       r_sector;
    t_stamp        r_now;

    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic          r_hit_dirty;
    logic          r_inv;
    logic [IW-1:0] r_inv_idx;
    logic          r_best_seen;
    logic [IW-1:0] r_best_idx;
    t_stamp        r_best_stamp;
    t_sector       r_best_tag;
    logic          r_best_dirty;

    logic          r_out_valid;
    logic          r_out_hit;
    t_slot_field   r_out_slot;
    logic          r_out_wb;
    t_sector       r_out_victim;

    t_sector       rd_tag;
    t_stamp        rd_stamp;
    logic          rd_valid;
    logic          rd_dirty;
    t_store_wr     wr;
    logic [IW-1:0] sel_idx;
    logic [IW+2:0] sel_ext;
    logic          wb;
    logic          accept;
    logic          out_free;

    sclw_store #(
        .SLOTS (CACHE_SLOTS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (r_rd_idx),
        .o_rd_tag   (rd_tag),
        .o_rd_stamp (rd_stamp),
        .o_rd_valid (rd_valid),
        .o_rd_dirty (rd_dirty),
        .i_wr       (wr),
        .i_wr_idx   (sel_idx)
    );

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign sel_idx  = r_hit ? r_hit_idx : (r_inv ? r_inv_idx : r_best_idx);
    assign sel_ext  = {3'b000, sel_idx};
    assign wb       = !r_hit && !r_inv && r_best_dirty;

    always_comb begin
        wr         = '0;
        wr.en      = (r_state == S_UPDATE) && out_free;
        wr.set_tag = !r_hit;
        wr.dirty   = r_hit ? (r_hit_dirty | r_mode) : r_mode;
        wr.tag     = r_sector;
        wr.stamp   = r_now;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_rd_idx == LAST_IDX) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_idx    <= '0;
            r_cmp_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cmp_en <= (r_state == S_SCAN);
            if (accept) begin
                r_rd_idx <= '0;
            end else if (r_state == S_SCAN && r_rd_idx != LAST_IDX) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_state == S_UPDATE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scan accumulators and request/result payload
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_rd_idx;
        if (accept) begin
            r_mode      <= i_mode;
            r_sector    <= i_sector_number;
            r_now       <= i_time_now;
            r_hit       <= 1'b0;
            r_inv       <= 1'b0;
            r_best_seen <= 1'b0;
        end else if (r_cmp_en) begin
            if (rd_valid && rd_tag == r_sector && !r_hit) begin
                r_hit       <= 1'b1;
                r_hit_idx   <= r_cmp_idx;
                r_hit_dirty <= rd_dirty;
            end
            if (!rd_valid && !r_inv) begin
                r_inv     <= 1'b1;
                r_inv_idx <= r_cmp_idx;
            end
            if (rd_valid && (!r_best_seen || rd_stamp < r_best_stamp)) begin
                r_best_seen  <= 1'b1;
                r_best_idx   <= r_cmp_idx;
                r_best_stamp <= rd_stamp;
                r_best_tag   <= rd_tag;
                r_best_dirty <= rd_dirty;
            end
        end
        if (r_state == S_UPDATE && out_free) begin
            r_out_hit    <= r_hit;
            r_out_slot   <= sel_ext[2:0];
            r_out_wb     <= wb;
            r_out_victim <= wb ? r_best_tag : '0;
        end
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_hit              = r_out_hit;
    assign o_slot             = r_out_slot;
    assign o_writeback_needed = r_out_wb;
    assign o_victim_sector    = r_out_victim;

    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> !o_writeback_needed)
        else $error("write-back reported on a hit");

    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_writeback_needed) |-> (o_victim_sector == '0))
        else $error("victim sector nonzero without write-back");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_SCAN))
        else $error("accepted word did not start a scan");

    a_cmp_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_en |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("compare outside scan window");

endmodule

@@ sv/sclw_store.sv @@
// ----------------------------------------------------------------------------
// sclw_store
// Slot store: tag and stamp memories with one registered read port and one
// write port, plus valid and dirty bits in flops cleared by reset.
// ----------------------------------------------------------------------------
module sclw_store #(
    parameter int SLOTS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [$clog2(SLOTS)-1:0]     i_rd_idx,
    output sclw_pkg::t_sector            o_rd_tag,
    output sclw_pkg::t_stamp             o_rd_stamp,
    output logic                         o_rd_valid,
    output logic                         o_rd_dirty,
    input  sclw_pkg::t_store_wr          i_wr,
    input  logic [$clog2(SLOTS)-1:0]     i_wr_idx
);
    import sclw_pkg::*;

    t_sector          r_tag_mem   [SLOTS];
    t_stamp           r_stamp_mem [SLOTS];
    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] r_dirty;
    t_sector          r_rd_tag;
    t_stamp           r_rd_stamp;
    logic             r_rd_valid;
    logic             r_rd_dirty;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_stamp_mem[i_wr_idx] <= i_wr.stamp;
            if (i_wr.set_tag) begin
                r_tag_mem[i_wr_idx] <= i_wr.tag;
            end
        end
        r_rd_tag   <= r_tag_mem[i_rd_idx];
        r_rd_stamp <= r_stamp_mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_dirty    <= '0;
            r_rd_valid <= 1'b0;
            r_rd_dirty <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_dirty[i_wr_idx] <= i_wr.dirty;
                if (i_wr.set_tag) begin
                    r_valid[i_wr_idx] <= 1'b1;
                end
            end
            r_rd_valid <= r_valid[i_rd_idx];
            r_rd_dirty <= r_dirty[i_rd_idx];
        end
    end

    assign o_rd_tag   = r_rd_tag;
    assign o_rd_stamp = r_rd_stamp;
    assign o_rd_valid = r_rd_valid;
    assign o_rd_dirty = r_rd_dirty;

endmodule

@@ sim/sector_cache_lru_writeback_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_cache_lru_writeback_test
// Self-checking bench for the sector cache tag and replacement controller.
// A directed table covers the first fill, hits, tie-breaks and dirty
// evictions. Random traffic over small sliding working sets follows, with
// random gaps on both channels and long output hold-offs. Every accepted
// request runs through a cache image kept in the bench, and every result
// word is checked in order against it or against the table's typed result.
// ----------------------------------------------------------------------------
module sector_cache_lru_writeback_test;
    import sclw_pkg::*;

    localparam int SLOTS       = 8;
    localparam int RAND_ITEMS  = 1950;
    localparam int PHASES      = 10;
    localparam int HOLD_CYCLES = 160;

    localparam logic MODE_RD = 1'b0;
    localparam logic MODE_WR = 1'b1;

    typedef struct packed {
        logic        hit;
        t_slot_field slot;
        logic        wb;
        t_sector     victim;
    } t_lookup;

    typedef struct packed {
        logic    mode;
        t_sector sector;
        t_stamp  stamp;
        logic    known;
        t_lookup res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_mode;
    t_sector     i_sector_number;
    t_stamp      i_time_now;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_hit;
    t_slot_field o_slot;
    logic        o_writeback_needed;
    t_sector     o_victim_sector;

    // cache image
    logic    img_valid [SLOTS];
    logic    img_dirty [SLOTS];
    t_sector img_tag   [SLOTS];
    t_stamp  img_stamp [SLOTS];

    t_lookup lookup_q [$];
    t_row    directed [17];

    int   n_sent   = 0;
    int   n_recv   = 0;
    int   n_hits   = 0;
    int   n_wb     = 0;
    int   n_errors = 0;
    logic send_calm = 1'b0;
    logic recv_calm = 1'b0;

    sector_cache_lru_writeback #(
        .CACHE_SLOTS (SLOTS)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_mode             (i_mode),
        .i_sector_number    (i_sector_number),
        .i_time_now         (i_time_now),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_hit              (o_hit),
        .o_slot             (o_slot),
        .o_writeback_needed (o_writeback_needed),
        .o_victim_sector    (o_victim_sector)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_lookup cache_access(input logic wr, input t_sector sec,
                                             input t_stamp now);
        t_lookup r;
        int      idx;
        int      oldest;
        r      = '0;
        idx    = -1;
        oldest = 0;
        for (int i = 0; i < SLOTS; i++)
            if (idx < 0 && img_valid[i] && img_tag[i] == sec)
                idx = i;
        if (idx >= 0) begin
            r.hit          = 1'b1;
            img_stamp[idx] = now;
            if (wr)
                img_dirty[idx] = 1'b1;
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (idx < 0) begin
                    if (!img_valid[i])
                        idx = i;
                    else if (img_stamp[i] < img_stamp[oldest])
                        oldest = i;
                end
            end
            if (idx < 0)
                idx = oldest;
            if (img_valid[idx] && img_dirty[idx]) begin
                r.wb     = 1'b1;
                r.victim = img_tag[idx];
            end
            img_valid[idx] = 1'b1;
            img_dirty[idx] = wr;
            img_tag[idx]   = sec;
            img_stamp[idx] = now;
        end
        r.slot = t_slot_field'(idx);
        return r;
    endfunction

    function automatic t_row row(input logic m, input t_sector s, input t_stamp t,
                                 input logic k, input logic h, input int sl,
                                 input logic w, input t_sector v);
        t_row x;
        x.mode       = m;
        x.sector     = s;
        x.stamp      = t;
        x.known      = k;
        x.res.hit    = h;
        x.res.slot   = t_slot_field'(sl);
        x.res.wb     = w;
        x.res.victim = v;
        return x;
    endfunction

    task automatic send_word(input logic wr, input t_sector sec, input t_stamp now,
                             input logic known, input t_lookup typed);
        int      gap;
        t_lookup r;
        gap = send_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= wr;
        i_sector_number <= sec;
        i_time_now      <= now;
        do @(posedge i_clk); while (o_in_stall);
        r = cache_access(wr, sec, now);
        lookup_q.push_back(known ? typed : r);
        n_sent++;
    endtask

    task automatic field_mismatch(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        n_errors++;
    endtask

    // result side
    initial begin
        int      hold;
        t_lookup want;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (n_recv == 400 || n_recv == 1300)
                hold = HOLD_CYCLES;
            else
                hold = recv_calm ? 0 : $urandom_range(0, 13);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            n_recv++;
            n_hits += o_hit;
            n_wb   += o_writeback_needed;
            if (lookup_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual hit=%0b slot=%0d wb=%0b victim=%0d",
                         $time, o_hit, o_slot, o_writeback_needed, o_victim_sector);
                n_errors++;
            end else begin
                want = lookup_q.pop_front();
                if (o_hit !== want.hit)
                    field_mismatch("hit", want.hit, o_hit);
                if (o_slot !== want.slot)
                    field_mismatch("slot", want.slot, o_slot);
                if (o_writeback_needed !== want.wb)
                    field_mismatch("writeback_needed", want.wb, o_writeback_needed);
                if (o_victim_sector !== want.victim)
                    field_mismatch("victim_sector", want.victim, o_victim_sector);
            end
        end
    end

    // request side
    initial begin
        int      pick;
        int      span;
        t_sector base;
        t_sector sec;
        t_stamp  stamp;
        t_stamp  tick;

        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_mode          <= MODE_RD;
        i_sector_number <= '0;
        i_time_now      <= '0;
        for (int i = 0; i < SLOTS; i++) begin
            img_valid[i] = 1'b0;
            img_dirty[i] = 1'b0;
            img_tag[i]   = '0;
            img_stamp[i] = '0;
        end

        //                     mode     sector     stamp          typed  hit slot wb victim
        directed[0]  = row(MODE_RD, 10'd0,    32'd0,          1'b1, 1'b0, 0, 1'b0, 10'd0);
        directed[1]  = row(MODE_WR, 10'd1023, 32'hFFFF_FFFF,  1'b1, 1'b0, 1, 1'b0, 10'd0);
        directed[2]  = row(MODE_WR, 10'd0,    32'd5,          1'b1, 1'b1, 0, 1'b0, 10'd0);
        directed[3]  = row(MODE_RD, 10'd1023, 32'd1,          1'b1, 1'b1, 1, 1'b0, 10'd0);
        directed[4]  = row(MODE_WR, 10'd512,  32'd1,          1'b0, 1'b0, 0, 1'b0, 10'd0);
        directed[5]  = row(MODE_RD, 10'h155,  32'd100,        1'b0, 1'b0, 0, 1'b0, 10'd0);
        directed[6]  = row(MODE_WR, 10'h2AA,  32'd200,        1'b0, 1'b0, 0, 1'b0, 10'd0);
        directed[7]  = row(MODE_RD, 10'd7,    32'd300,        1'b0, 1'b0, 0, 1'b0, 10'd0);
        directed[8]  = row(MODE_RD, 10'd8,    32'd400,        1'b0, 1'b0, 0, 1'b0, 10'd0);
        directed[9]  = row(MODE_WR, 10'd9,    32'd500,        1'b0, 1'b0, 0, 1'b0, 10'd0);
        // full: slots 1 and 2 tie on the smallest stamp, lower one goes first
        directed[10] = row(MODE_RD, 10'd20,   32'd600,        1'b1, 1'b0, 1, 1'b1, 10'd1023);
        directed[11] = row(MODE_RD, 10'd21,   32'd601,        1'b1, 1'b0, 2, 1'b1, 10'd512);
        directed[12] = row(MODE_RD, 10'd22,   32'd602,        1'b1, 1'b0, 0, 1'b1, 10'd0);
        directed[13] = row(MODE_RD, 10'd23,   32'd603,        1'b0, 1'b0, 0, 1'b0, 10'd0);
        directed[14] = row(MODE_WR, 10'd20,   32'd0,          1'b1, 1'b1, 1, 1'b0, 10'd0);
        directed[15] = row(MODE_RD, 10'd24,   32'd700,        1'b0, 1'b0, 0, 1'b0, 10'd0);
        directed[16] = row(MODE_RD, 10'd24,   32'hFFFF_FFFF,  1'b1, 1'b1, 1, 1'b0, 10'd0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[n])
            send_word(directed[n].mode, directed[n].sector, directed[n].stamp,
                      directed[n].known, directed[n].res);

        for (int ph = 0; ph < PHASES; ph++) begin
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            base      = t_sector'($urandom);
            span      = $urandom_range(9, 16);
            tick      = $urandom;
            for (int k = 0; k < RAND_ITEMS / PHASES; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    sec = base + t_sector'($urandom_range(0, span - 1));
                else
                    sec = t_sector'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    tick  = tick + t_stamp'($urandom_range(0, 3));
                    stamp = tick;
                end else if (pick < 85)
                    stamp = $urandom;
                else
                    stamp = t_stamp'($urandom_range(0, 15));
                send_word(logic'($urandom_range(0, 1)), sec, stamp, 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;

        while (lookup_q.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("%0d requests (directed fill, tie-break, dirty eviction, then random sets)",
                 n_sent);
        $display("%0d hits, %0d write-backs, two long output hold-offs, %0d mismatches",
                 n_hits, n_wb, n_errors);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d words still pending", $time, lookup_q.size());
        $display("FAILURE");
        $finish;
    end

endmodule
